FILE: hw/rtl/deq_pkg.sv
package deq_pkg;

  // Sizes
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned STATUS_W        = 2;

  // Command codes on the input port
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST
  } op_e;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } back_state_e;

  // One queued command
  typedef struct packed {
    op_e                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic                       strobe;
    logic [STATUS_W-1:0]        status;
    logic signed [WORD_W-1:0]   value;
    logic                       last;
  } result_t;

endpackage

FILE: hw/rtl/deq_front.sv
module deq_front (
  input  logic                                    start_i,
  input  logic [deq_pkg::CMD_W-1:0]               command_i,
  input  logic signed [deq_pkg::WORD_W-1:0]       value_in_i,
  input  logic                                    full_i,
  output logic                                    busy_o,
  output logic                                    push_o,
  output deq_pkg::cmd_t                           entry_o
);

  logic          known;
  deq_pkg::op_e  op;

  // Decode the command; unknown codes are accepted and dropped
  always_comb begin
    known = 1'b1;
    op    = deq_pkg::OP_PUSH_FRONT;
    case (command_i)
      deq_pkg::CMD_PUSH_FRONT: op = deq_pkg::OP_PUSH_FRONT;
      deq_pkg::CMD_PUSH_BACK:  op = deq_pkg::OP_PUSH_BACK;
      deq_pkg::CMD_POP_FRONT:  op = deq_pkg::OP_POP_FRONT;
      deq_pkg::CMD_POP_BACK:   op = deq_pkg::OP_POP_BACK;
      deq_pkg::CMD_LIST:       op = deq_pkg::OP_LIST;
      default:                 known = 1'b0;
    endcase
  end

  assign busy_o         = full_i;
  assign push_o         = start_i && !full_i && known;
  assign entry_o.op     = op;
  assign entry_o.value  = value_in_i;

endmodule

FILE: hw/rtl/deq_cmd_fifo.sv
module deq_cmd_fifo #(
  parameter int unsigned DEPTH = deq_pkg::CMD_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  deq_pkg::cmd_t entry_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output deq_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  deq_pkg::cmd_t      slot_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: hw/rtl/deq_back.sv
module deq_back #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  deq_pkg::cmd_t    entry_i,
  output logic             pop_o,
  output deq_pkg::result_t result_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW:0] DepthW = (PtrW + 1)'(DEPTH);

  // Ring store
  logic signed [deq_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [deq_pkg::WORD_W-1:0] rdata_q;

  logic [PtrW-1:0]        front_q, front_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [PtrW-1:0]        idx_q, idx_d;
  deq_pkg::back_state_e   state_q, state_d;
  logic                   rd_pend_q, rd_last_q, rd_last_d;

  logic                   take, full, empty;
  logic                   we, re;
  logic [PtrW-1:0]        waddr, raddr;
  logic                   imm;
  logic [deq_pkg::STATUS_W-1:0] imm_status;
  deq_pkg::result_t       res_q, res_d;

  // Position a + b modulo DEPTH, both operands below DEPTH
  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] a,
                                               input logic [PtrW-1:0] b);
    logic [PtrW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[PtrW-1:0];
  endfunction

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);
  assign take  = (state_q == deq_pkg::BK_IDLE) && !rd_pend_q && valid_i;
  assign pop_o = take;

  // Command execution
  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    idx_d      = idx_q;
    we         = 1'b0;
    waddr      = front_q;
    re         = 1'b0;
    raddr      = front_q;
    rd_last_d  = 1'b1;
    imm        = 1'b0;
    imm_status = deq_pkg::ST_OK;
    case (state_q)
      deq_pkg::BK_IDLE: begin
        if (take) begin
          case (entry_i.op)
            deq_pkg::OP_PUSH_FRONT: begin
              imm = 1'b1;
              if (full) begin
                imm_status = deq_pkg::ST_FULL;
              end else begin
                front_d = (front_q == '0) ? PtrW'(DEPTH - 1) : front_q - 1'b1;
                we      = 1'b1;
                waddr   = front_d;
                count_d = count_q + 1'b1;
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              imm = 1'b1;
              if (full) begin
                imm_status = deq_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = wrap_add(front_q, count_q[PtrW-1:0]);
                count_d = count_q + 1'b1;
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                imm        = 1'b1;
                imm_status = deq_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = front_q;
                front_d = wrap_add(front_q, PtrW'(1));
                count_d = count_q - 1'b1;
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (empty) begin
                imm        = 1'b1;
                imm_status = deq_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = wrap_add(front_q, PtrW'(count_q - 1'b1));
                count_d = count_q - 1'b1;
              end
            end
            deq_pkg::OP_LIST: begin
              if (empty) begin
                imm        = 1'b1;
                imm_status = deq_pkg::ST_EMPTY;
              end else begin
                state_d = deq_pkg::BK_LIST;
                idx_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      deq_pkg::BK_LIST: begin
        // One store read per cycle, front to back
        re        = 1'b1;
        raddr     = wrap_add(front_q, idx_q);
        rd_last_d = ((CntW'(idx_q) + 1'b1) == count_q);
        idx_d     = idx_q + 1'b1;
        if (rd_last_d) begin
          state_d = deq_pkg::BK_IDLE;
        end
      end
      default: state_d = deq_pkg::BK_IDLE;
    endcase
  end

  // Result register: store read data or an immediate status
  always_comb begin
    res_d        = res_q;
    res_d.strobe = 1'b0;
    if (rd_pend_q) begin
      res_d.strobe = 1'b1;
      res_d.status = deq_pkg::ST_OK;
      res_d.value  = rdata_q;
      res_d.last   = rd_last_q;
    end else if (imm) begin
      res_d.strobe = 1'b1;
      res_d.status = imm_status;
      res_d.value  = '0;
      res_d.last   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= deq_pkg::BK_IDLE;
      front_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      rd_pend_q    <= re;
      rd_last_q    <= rd_last_d;
      res_q        <= res_d;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= entry_i.value;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign result_o = res_q;

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   command_i, value_in_i
// result    out        strobe, one cycle      status_o, value_out_o, last_o
//
// A push, or any full or empty result, is registered once into the result
// register; a pop result also passes through the registered ring store read.
// A list of N entries strobes N results on consecutive cycles.
// The back end takes one command per cycle for pushes, while the command queue
// holds one; after a pop or a list it waits until the store reads are done. A
// two-entry command queue buffers the front. Reset leaves the queue empty; busy
// is high while that command queue is full. The receiver cannot stall.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [deq_pkg::CMD_W-1:0]                command_i,
  input  logic signed [deq_pkg::WORD_W-1:0]        value_in_i,
  output logic                                     strobe,
  output logic [deq_pkg::STATUS_W-1:0]             status_o,
  output logic signed [deq_pkg::WORD_W-1:0]        value_out_o,
  output logic                                     last_o
);

  logic             push, full, valid, pop;
  deq_pkg::cmd_t    entry, head;
  deq_pkg::result_t result;

  deq_front u_front (
    .start_i    (start),
    .command_i  (command_i),
    .value_in_i (value_in_i),
    .full_i     (full),
    .busy_o     (busy),
    .push_o     (push),
    .entry_o    (entry)
  );

  deq_cmd_fifo #(
    .DEPTH (deq_pkg::CMD_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .valid_o (valid),
    .full_o  (full),
    .head_o  (head)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid),
    .entry_i  (head),
    .pop_o    (pop),
    .result_o (result)
  );

  assign strobe      = result.strobe;
  assign status_o    = result.status;
  assign value_out_o = result.value;
  assign last_o      = result.last;

endmodule

FILE: hw/rtl/deq_checker.sv
module deq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [deq_pkg::CMD_W-1:0]           command_i,
  input logic signed [deq_pkg::WORD_W-1:0]   value_in_i,
  input logic                                strobe,
  input logic [deq_pkg::STATUS_W-1:0]        status_o,
  input logic signed [deq_pkg::WORD_W-1:0]   value_out_o,
  input logic                                last_o
);

  // Full and empty results stand alone
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && status_o != deq_pkg::ST_OK |-> last_o)
    else $error("full or empty result without last");

  // Full and empty results carry no word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && status_o != deq_pkg::ST_OK |-> value_out_o == '0)
    else $error("full or empty result with nonzero value");

  // A list continues without a gap and with ok status
  a_list_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !last_o |=> strobe && status_o == deq_pkg::ST_OK)
    else $error("list transaction broken");

  // No result strobe on the edge where reset is released
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !strobe)
    else $error("result right after reset");

endmodule

bind double_ended_queue deq_checker u_chk (.*);

FILE: bench/tb_double_ended_queue.sv
module tb_double_ended_queue;

  typedef logic signed [deq_pkg::WORD_W-1:0] word_t;
  typedef logic [deq_pkg::CMD_W-1:0] cmd_code_t;
  typedef logic [deq_pkg::STATUS_W-1:0] status_t;

  // Codes outside the command set; the block drops them without a result
  localparam cmd_code_t CMD_RESERVED_A = 3'd5;
  localparam cmd_code_t CMD_RESERVED_B = 3'd6;
  localparam cmd_code_t CMD_RESERVED_C = 3'd7;

  localparam int unsigned RING = deq_pkg::DEPTH_DEF;
  // Watchdog limit on quiet cycles, far above a full list plus a pop backlog
  localparam int unsigned QUIET_LIMIT = 2000;

  // One result transaction as seen on the ports
  typedef struct packed {
    status_t status;
    word_t   value;
    logic    last;
  } res_t;

  // One row of the directed plan; typed rows carry their own single result
  typedef struct packed {
    cmd_code_t  cmd;
    word_t      word;
    logic [4:0] reps;
    logic       typed;
    status_t    status;
    word_t      value;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  cmd_code_t command_i;
  word_t     value_in_i;
  logic      strobe;
  status_t   status_o;
  word_t     value_out_o;
  logic      last_o;

  // Tag that travels with the command transaction on the same edge
  logic row_typed;
  res_t row_exp;

  // Shadow deque
  word_t       ring [RING];
  int unsigned head;
  int unsigned fill;

  res_t        due_q [$];
  int unsigned n_errors;
  int unsigned quiet_cycles;

  // Repeated rows send word, word+1 and onward as their words
  row_t plan [24] = '{
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, deq_pkg::ST_EMPTY, 32'h0},
    '{deq_pkg::CMD_POP_BACK,   32'h5a5a_5a5a, 5'd1,  1'b1, deq_pkg::ST_EMPTY, 32'h0},
    '{deq_pkg::CMD_LIST,       32'hffff_ffff, 5'd1,  1'b1, deq_pkg::ST_EMPTY, 32'h0},
    '{CMD_RESERVED_A,          32'hffff_ffff, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 5'd1,  1'b1, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_BACK,  32'h0000_0000, 5'd1,  1'b1, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff, 5'd1,  1'b1, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_LIST,       32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_FRONT, 32'h1234_0000, 5'd14, 1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_BACK,  32'h0000_0001, 5'd1,  1'b1, deq_pkg::ST_FULL,  32'h0},
    '{deq_pkg::CMD_PUSH_FRONT, 32'h0000_0002, 5'd1,  1'b1, deq_pkg::ST_FULL,  32'h0},
    '{deq_pkg::CMD_LIST,       32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd16, 1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, deq_pkg::ST_EMPTY, 32'h0},
    '{CMD_RESERVED_B,          32'h8000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{CMD_RESERVED_C,          32'h7fff_ffff, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_PUSH_BACK,  32'h8000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0},
    '{deq_pkg::CMD_LIST,       32'h0000_0000, 5'd1,  1'b0, deq_pkg::ST_OK,    32'h0}
  };

  double_ended_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .value_in_i  (value_in_i),
    .strobe      (strobe),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR @%0t %s: got %0h, expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  // Advance the shadow deque by one command and queue the results it gives
  function automatic void apply_cmd(input cmd_code_t cmd, input word_t word,
                                    input bit keep);
    res_t        outs [$];
    int unsigned k;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (fill >= RING) begin
          outs.push_back('{deq_pkg::ST_FULL, '0, 1'b1});
        end else begin
          if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
            head = (head + RING - 1) % RING;
            ring[head] = word;
          end else begin
            ring[(head + fill) % RING] = word;
          end
          fill++;
          outs.push_back('{deq_pkg::ST_OK, '0, 1'b1});
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (fill == 0) begin
          outs.push_back('{deq_pkg::ST_EMPTY, '0, 1'b1});
        end else if (cmd == deq_pkg::CMD_POP_FRONT) begin
          outs.push_back('{deq_pkg::ST_OK, ring[head], 1'b1});
          head = (head + 1) % RING;
          fill--;
        end else begin
          outs.push_back('{deq_pkg::ST_OK, ring[(head + fill - 1) % RING], 1'b1});
          fill--;
        end
      end
      deq_pkg::CMD_LIST: begin
        if (fill == 0) begin
          outs.push_back('{deq_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          for (k = 0; k < fill; k++) begin
            outs.push_back('{deq_pkg::ST_OK, ring[(head + k) % RING], (k + 1 == fill)});
          end
        end
      end
      default: ;
    endcase
    if (keep) begin
      foreach (outs[i]) due_q.push_back(outs[i]);
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (due_q.size() == 0) begin
      report("result with nothing pending", value_out_o, 32'h0);
    end else begin
      want = due_q.pop_front();
      if (status_o !== want.status) report("status", status_o, want.status);
      if (value_out_o !== want.value) report("value_out", value_out_o, want.value);
      if (last_o !== want.last) report("last", last_o, want.last);
    end
  endtask

  // Monitor: predict on command transactions, check result transactions, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_cmd(command_i, value_in_i, !row_typed);
        if (row_typed) due_q.push_back(row_exp);
      end
      if (strobe) check_result();
      if ((start && !busy) || strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one command transaction, with a random gap in front of it
  task automatic send_item(input cmd_code_t cmd, input word_t word, input bit typed,
                           input res_t want, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    value_in_i <= word;
    row_typed  <= typed;
    row_exp    <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold the sender off until every pending result is back
  task automatic drain_all();
    start <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
  endtask

  // Random traffic in fill and drain spells, so full and empty both come up
  task automatic run_random(input int unsigned items, input int unsigned idle_pct);
    int unsigned sent;
    int unsigned r;
    bit          filling;
    cmd_code_t   cmd;
    word_t       word;
    sent    = 0;
    filling = 1'b1;
    while (sent < items) begin
      if ($urandom_range(15) == 0) filling = ~filling;
      r = $urandom_range(99);
      if (r < 4) cmd = deq_pkg::CMD_W'($urandom_range(CMD_RESERVED_C, CMD_RESERVED_A));
      else if (r < 14) cmd = deq_pkg::CMD_LIST;
      else if ((r < 70) == filling) begin
        cmd = $urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
      end else begin
        cmd = $urandom_range(1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
      end
      case ($urandom_range(7))
        0: word = 32'h7fff_ffff;
        1: word = 32'h8000_0000;
        default: word = $urandom;
      endcase
      send_item(cmd, word, 1'b0, '0, idle_pct);
      if (cmd <= deq_pkg::CMD_LIST) sent++;
    end
  endtask

  initial begin
    row_t row;
    res_t want;
    int   k;
    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = deq_pkg::CMD_PUSH_FRONT;
    value_in_i   = '0;
    row_typed    = 1'b0;
    row_exp      = '0;
    head         = 0;
    fill         = 0;
    n_errors     = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan
    foreach (plan[i]) begin
      row  = plan[i];
      want = '{row.status, row.value, 1'b1};
      for (k = 0; k < row.reps; k++) begin
        send_item(row.cmd, row.word + k, row.typed, want, 35);
      end
    end
    drain_all();

    // Random phases: light gaps, heavy gaps, back to back
    run_random(80, 35);
    drain_all();
    run_random(80, 74);
    drain_all();
    run_random(80, 0);
    drain_all();
    repeat (40) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_front.sv
hw/rtl/deq_cmd_fifo.sv
hw/rtl/deq_back.sv
hw/rtl/double_ended_queue.sv
hw/rtl/deq_checker.sv
bench/tb_double_ended_queue.sv
